// ===== rtl/arwc_pkg.sv =====
`timescale 1ns / 1ps
package arwc_pkg;

    localparam int WINDOW_BITS_DEF = 64;

    localparam int NONCE_W    = 32;
    localparam int CTR_W      = 32;
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = NONCE_W + NONCE_W + CTR_W + TIME_W;
    localparam int OUT_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERFLOW_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGEN_INTERVAL  = 1'b1;

    localparam logic [LIMIT_W-1:0] UNDERFLOW_LIMIT_RST = 4'd8;
    localparam logic [TIME_W-1:0]  REGEN_INTERVAL_RST  = 32'd3000;

    typedef logic [1:0] t_reason;
    localparam t_reason REASON_OK      = 2'd0;
    localparam t_reason REASON_BAD_TAG = 2'd1;
    localparam t_reason REASON_DUP     = 2'd2;
    localparam t_reason REASON_OLD     = 2'd3;

    typedef struct packed {
        logic [NONCE_W-1:0] current_nonce;
        logic [NONCE_W-1:0] frame_nonce;
        logic [CTR_W-1:0]   frame_counter;
        logic [TIME_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic    accepted;
        t_reason reject_reason;
        logic    regen_request;
    } t_result;

    typedef struct packed {
        logic [LIMIT_W-1:0] underflow_limit;
        logic [TIME_W-1:0]  regen_interval_ms;
    } t_cfg;

endpackage

// ===== rtl/arwc_cfg_regs.sv =====
`timescale 1ns / 1ps
module arwc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [arwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [arwc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output arwc_pkg::t_cfg                   o_cfg
);
    import arwc_pkg::*;

    logic [LIMIT_W-1:0] r_underflow_limit;
    logic [TIME_W-1:0]  r_regen_interval;
    logic               wr;

    assign o_cfg_ready = 1'b1;
    assign wr = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_underflow_limit <= UNDERFLOW_LIMIT_RST;
            r_regen_interval  <= REGEN_INTERVAL_RST;
        end else if (wr) begin
            case (i_cfg_index)
                CFG_UNDERFLOW_LIMIT: r_underflow_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_REGEN_INTERVAL:  r_regen_interval  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.underflow_limit   = r_underflow_limit;
    assign o_cfg.regen_interval_ms = r_regen_interval;

endmodule

// ===== rtl/arwc_window.sv =====
`timescale 1ns / 1ps
module arwc_window #(
    parameter int WINDOW_BITS = arwc_pkg::WINDOW_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  arwc_pkg::t_item   i_item,
    input  arwc_pkg::t_cfg    i_cfg,
    output arwc_pkg::t_result o_result
);
    import arwc_pkg::*;

    localparam int          SHW      = $clog2(WINDOW_BITS);
    localparam logic [CTR_W-1:0] WIN_SIZE = CTR_W'(WINDOW_BITS);

    logic [NONCE_W-1:0]     r_window_nonce, n_window_nonce;
    logic [CTR_W-1:0]       r_window_top,   n_window_top;
    logic [WINDOW_BITS-1:0] r_seen,         n_seen;
    logic [LIMIT_W-1:0]     r_old_count,    n_old_count;
    logic [TIME_W-1:0]      r_last_regen,   n_last_regen;

    logic                   nonce_new;
    logic [CTR_W-1:0]       eff_top;
    logic [WINDOW_BITS-1:0] eff_seen;
    logic [LIMIT_W-1:0]     eff_count;
    logic                   tag_bad;
    logic                   advance;
    logic [CTR_W-1:0]       shift_amt;
    logic [CTR_W-1:0]       diff;
    logic                   in_window;
    logic [WINDOW_BITS-1:0] seen_shifted;
    logic [WINDOW_BITS-1:0] age_bit;
    logic                   dup;
    logic [LIMIT_W:0]       cnt_inc;
    logic                   limit_hit;
    logic [TIME_W-1:0]      elapsed;
    logic                   regen_ok;

    // a new challenge nonce restarts the window before the frame is judged
    assign nonce_new = i_item.current_nonce != r_window_nonce;
    assign eff_top   = nonce_new ? '0 : r_window_top;
    assign eff_seen  = nonce_new ? '0 : r_seen;
    assign eff_count = nonce_new ? '0 : r_old_count;

    assign tag_bad   = (i_item.frame_nonce != i_item.current_nonce) ||
                       (i_item.frame_counter == '0);
    assign advance   = i_item.frame_counter > eff_top;
    assign shift_amt = i_item.frame_counter - eff_top;
    assign diff      = eff_top - i_item.frame_counter;
    assign in_window = diff < WIN_SIZE;

    assign seen_shifted = (shift_amt < WIN_SIZE) ? (eff_seen << shift_amt[SHW-1:0]) : '0;
    assign age_bit      = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << diff[SHW-1:0];
    assign dup          = |(eff_seen & age_bit);

    assign cnt_inc   = {1'b0, eff_count} + {{LIMIT_W{1'b0}}, 1'b1};
    assign limit_hit = cnt_inc >= {1'b0, i_cfg.underflow_limit};
    assign elapsed   = i_item.now_ms - r_last_regen;
    assign regen_ok  = elapsed > i_cfg.regen_interval_ms;

    always_comb begin
        n_window_nonce = i_item.current_nonce;
        n_window_top   = eff_top;
        n_seen         = eff_seen;
        n_old_count    = eff_count;
        n_last_regen   = r_last_regen;
        o_result.accepted      = 1'b0;
        o_result.reject_reason = REASON_BAD_TAG;
        o_result.regen_request = 1'b0;
        if (tag_bad) begin
            o_result.reject_reason = REASON_BAD_TAG;
        end else if (advance) begin
            n_seen       = seen_shifted | {{(WINDOW_BITS-1){1'b0}}, 1'b1};
            n_window_top = i_item.frame_counter;
            n_old_count  = '0;
            o_result.accepted      = 1'b1;
            o_result.reject_reason = REASON_OK;
        end else if (in_window) begin
            if (dup) begin
                o_result.reject_reason = REASON_DUP;
            end else begin
                n_seen = eff_seen | age_bit;
                o_result.accepted      = 1'b1;
                o_result.reject_reason = REASON_OK;
            end
        end else begin
            o_result.reject_reason = REASON_OLD;
            if (limit_hit) begin
                n_old_count = '0;
                if (regen_ok) begin
                    n_last_regen = i_item.now_ms;
                    o_result.regen_request = 1'b1;
                end
            end else begin
                n_old_count = cnt_inc[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_nonce <= '0;
            r_window_top   <= '0;
            r_seen         <= '0;
            r_old_count    <= '0;
            r_last_regen   <= '0;
        end else if (i_fire) begin
            r_window_nonce <= n_window_nonce;
            r_window_top   <= n_window_top;
            r_seen         <= n_seen;
            r_old_count    <= n_old_count;
            r_last_regen   <= n_last_regen;
        end
    end

endmodule

// ===== rtl/anti_replay_window_check.sv =====
`timescale 1ns / 1ps
// Sliding-window anti-replay check. Each beat on the slave side carries one
// frame tag with the receiver's current nonce and the time. One result beat
// comes out per tag. The tag is registered in the input register, and its
// result is registered in the result register that drives the master side.
// With the master side ready, a new tag is accepted every cycle.
// The window state (nonce, top, seen bitmap, too-old count, last regen time)
// is updated by the compare/shift logic between the input
// register and the result register, so each tag sees everything the previous
// one left. While a result waits on the master side, the next tag is held in
// the input register and is judged on the cycle the result is taken.
module anti_replay_window_check #(
    parameter int WINDOW_BITS = arwc_pkg::WINDOW_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // current_nonce, frame_nonce, frame_counter, now_ms
    input  logic [arwc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // accepted, reject_reason[1:0], regen_request, zero pad
    output logic [arwc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [arwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [arwc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import arwc_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    t_result result;
    t_cfg    cfg;
    logic    fire;
    logic    in_take;

    arwc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    arwc_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.current_nonce <= s_axis_tdata[NONCE_W-1:0];
            r_in_item.frame_nonce   <= s_axis_tdata[2*NONCE_W-1:NONCE_W];
            r_in_item.frame_counter <= s_axis_tdata[2*NONCE_W+CTR_W-1:2*NONCE_W];
            r_in_item.now_ms        <= s_axis_tdata[IN_DATA_W-1:2*NONCE_W+CTR_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_result.regen_request,
                            r_out_result.reject_reason, r_out_result.accepted};

endmodule
